@@ design/mgf_pkg.sv @@
// Shared types, constants and helper functions for the morphological gradient filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package mgf_pkg;

  localparam int PIX_W     = 8;
  localparam int WIN       = 7;
  localparam int HALF_MAX  = (WIN - 1) / 2;
  localparam int LINES     = WIN - 1;
  localparam int CELLS     = WIN * WIN;
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 12;
  localparam int HALF_W    = 2;
  localparam int FILL_W    = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 1);
  localparam int CFG_IDX_W = 3;

  typedef logic [PIX_W-1:0]                     pixel_t;
  typedef logic [LINES-1:0][PIX_W-1:0]          line_word_t;
  typedef logic [WIN-1:0][PIX_W-1:0]            rows_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0]   window_t;
  typedef logic [CELLS-1:0]                     cells_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_HALF_W = 3'd2,
    REG_HALF_H = 3'd3,
    REG_MASK   = 3'd4
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(480);
  localparam logic [HALF_W-1:0] RST_HALF   = HALF_W'(1);
  localparam cells_t            RST_MASK   = '1;
  localparam logic [DIM_W-1:0]  WIDTH_LIM  = DIM_W'(MAX_WIDTH);

  // window metadata that travels with a word
  typedef struct packed {
    logic interior;
    logic last;
  } meta_t;

  // pipeline load enables from the top-level control
  typedef struct packed {
    logic s2_load;
    logic out_load;
  } adv_t;

  function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] h);
    return (int'(h) > HALF_MAX) ? HALF_W'(HALF_MAX) : h;
  endfunction

  // cell (r,c) holds the pixel r rows and c columns back from the newest one
  function automatic cells_t cell_select(input logic [HALF_W-1:0] hh,
                                         input logic [HALF_W-1:0] hw,
                                         input cells_t mask);
    cells_t sel;
    sel = '0;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        if (r <= 2 * int'(hh) && c <= 2 * int'(hw)) begin
          sel[r*WIN+c] = mask[(int'(hh) + HALF_MAX - r) * WIN + int'(hw) + HALF_MAX - c];
        end
      end
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

@@ design/mgf_line_buffer.sv @@
// Line memory: one word per column holding the pixels of the previous rows.
// Registered read with write-to-read forwarding. Uses mgf_pkg.
`default_nettype none

module mgf_line_buffer (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [mgf_pkg::COL_W-1:0] wr_addr,
  input  wire mgf_pkg::line_word_t      wr_data,
  input  wire logic [mgf_pkg::COL_W-1:0] rd_addr,
  output mgf_pkg::line_word_t           rd_data
);
  import mgf_pkg::*;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_q;
  line_word_t fwd_word;
  logic       fwd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    fwd_word <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_valid ? fwd_word : rd_q;

endmodule

`default_nettype wire

@@ design/mgf_window.sv @@
// 7x7 window of shift registers fed by the newest pixel and the line memory taps.
// Uses mgf_pkg.
`default_nettype none

module mgf_window (
  input  wire logic                clk,
  input  wire logic                shift_en,
  input  wire mgf_pkg::pixel_t     row0,
  input  wire mgf_pkg::line_word_t taps,
  output mgf_pkg::window_t         win
);
  import mgf_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < WIN; r++) begin
        if (r == 0) begin
          win[r][0] <= row0;
        end else begin
          win[r][0] <= taps[r-1];
        end
        for (int c = 1; c < WIN; c++) begin
          win[r][c] <= win[r][c-1];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mgf_reduce.sv @@
// Masked max/min reduction: per-row stage, then final stage with wrapping subtract.
// Uses mgf_pkg.
`default_nettype none

module mgf_reduce (
  input  wire logic             clk,
  input  wire mgf_pkg::adv_t    adv,
  input  wire mgf_pkg::window_t win,
  input  wire mgf_pkg::cells_t  sel,
  input  wire mgf_pkg::meta_t   meta1,
  output mgf_pkg::pixel_t       gradient,
  output logic                  frame_last
);
  import mgf_pkg::*;

  rows_t  rmax_c;
  rows_t  rmin_c;
  rows_t  row_max;
  rows_t  row_min;
  meta_t  meta2;
  pixel_t hi;
  pixel_t lo;

  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      rmax_c[r] = '0;
      rmin_c[r] = '1;
      for (int c = 0; c < WIN; c++) begin
        if (sel[r*WIN+c] && win[r][c] > rmax_c[r]) rmax_c[r] = win[r][c];
        if (sel[r*WIN+c] && win[r][c] < rmin_c[r]) rmin_c[r] = win[r][c];
      end
    end
  end

  always_comb begin
    hi = '0;
    lo = '1;
    for (int r = 0; r < WIN; r++) begin
      if (row_max[r] > hi) hi = row_max[r];
      if (row_min[r] < lo) lo = row_min[r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2_load) begin
      row_max <= rmax_c;
      row_min <= rmin_c;
      meta2   <= meta1;
    end
    if (adv.out_load) begin
      gradient   <= meta2.interior ? pixel_t'(hi - lo) : '0;
      frame_last <= meta2.last;
    end
  end

endmodule

`default_nettype wire

@@ design/morphological_gradient_filter.sv @@
// Morphological gradient filter, top level: configuration, position counters, flow control.
// Uses mgf_pkg, mgf_line_buffer, mgf_window, mgf_reduce.
//
// Takes one grayscale pixel per clock in raster order and returns max minus min (mod 256)
// over the masked window, up to 7x7. A word is accepted every cycle while the output side
// keeps up; the single line memory (one write and one read per cycle) sets that rate.
// A result passes the window registers, the row stage and the output register after its last word.
// The first half_height*width+half_width words of a frame give no result; every later word
// gives one, so pad words flush the tail. Border positions give 0; frame_last marks the last
// one, after which a new frame starts. Writing width, height or a radius restarts the frame.
// The line memory needs no clearing after reset: only pixels of the current frame are read.
`default_nettype none

module morphological_gradient_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output logic                               pixel_ready,
  input  wire logic [mgf_pkg::PIX_W-1:0]     pixel,
  input  wire logic                          pad,
  output logic                               gradient_valid,
  input  wire logic                          gradient_ready,
  output logic [mgf_pkg::PIX_W-1:0]          gradient,
  output logic                               frame_last,
  input  wire logic                          cfg_we,
  input  wire logic [mgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mgf_pkg::CELLS-1:0]     cfg_data
);
  import mgf_pkg::*;

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [HALF_W-1:0] half_width;
  logic [HALF_W-1:0] half_height;
  cells_t            element_mask;
  cells_t            sel;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [DIM_W-1:0]  w_last;
  logic [HALF_W-1:0] hh_eff;
  logic [HALF_W-1:0] hw_eff;
  logic [FILL_W-1:0] lag;

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [FILL_W-1:0] fill;
  logic [DIM_W-1:0]  q_row;
  logic [COL_W-1:0]  q_col;

  logic   s1_valid;
  logic   s2_valid;
  logic   out_free;
  logic   s2_free;
  logic   accept;
  logic   restart;
  logic   produce;
  logic   last;
  logic   interior;
  logic   col_wrap;
  meta_t  meta1;
  adv_t   adv;
  pixel_t val;

  line_word_t taps;
  line_word_t line_wr;
  window_t    win;

  assign w_eff  = (image_width == '0) ? DIM_W'(1) :
                  (image_width > WIDTH_LIM) ? WIDTH_LIM : image_width;
  assign h_eff  = (image_height == '0) ? DIM_W'(1) : image_height;
  assign w_last = w_eff - DIM_W'(1);
  assign hh_eff = eff_half(half_height);
  assign hw_eff = eff_half(half_width);
  assign lag    = FILL_W'(FILL_W'(hh_eff) * FILL_W'(w_eff) + FILL_W'(hw_eff));

  assign out_free    = !gradient_valid || gradient_ready;
  assign s2_free     = !s2_valid || out_free;
  assign pixel_ready = !s1_valid || s2_free;
  assign accept      = pixel_valid && pixel_ready;
  assign adv         = '{s2_load: s2_free, out_load: out_free};

  assign restart  = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                               cfg_index == REG_HALF_W || cfg_index == REG_HALF_H);
  assign produce  = (fill == lag);
  assign col_wrap = (DIM_W'(col) == w_last);
  assign last     = produce && (q_row == h_eff - DIM_W'(1)) && (DIM_W'(q_col) == w_last);
  assign interior = (q_row >= DIM_W'(hh_eff)) &&
                    ((DIM_W+1)'(q_row) + (DIM_W+1)'(hh_eff) < (DIM_W+1)'(h_eff)) &&
                    (DIM_W'(q_col) >= DIM_W'(hw_eff)) &&
                    ((DIM_W+1)'(q_col) + (DIM_W+1)'(hw_eff) < (DIM_W+1)'(w_eff));
  assign val      = pad ? '0 : pixel;

  always_comb begin
    line_wr[0] = val;
    for (int k = 1; k < LINES; k++) begin
      line_wr[k] = taps[k-1];
    end
  end

  always_comb begin
    priority if (restart) begin
      col_next = '0;
    end else if (accept) begin
      col_next = (last || col_wrap) ? '0 : col + COL_W'(1);
    end else begin
      col_next = col;
    end
  end

  always_ff @(posedge clk) begin
    sel <= cell_select(hh_eff, hw_eff, element_mask);
    if (accept) begin
      meta1 <= '{interior: interior, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_WIDTH;
      image_height   <= RST_HEIGHT;
      half_width     <= RST_HALF;
      half_height    <= RST_HALF;
      element_mask   <= RST_MASK;
      col            <= '0;
      fill           <= '0;
      q_row          <= '0;
      q_col          <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      gradient_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
          REG_HALF_W: half_width   <= cfg_data[HALF_W-1:0];
          REG_HALF_H: half_height  <= cfg_data[HALF_W-1:0];
          REG_MASK:   element_mask <= cfg_data;
          default:    ;
        endcase
      end

      col <= col_next;
      if (restart || (accept && last)) begin
        fill  <= '0;
        q_row <= '0;
        q_col <= '0;
      end else if (accept) begin
        if (!produce) begin
          fill <= fill + FILL_W'(1);
        end else if (DIM_W'(q_col) == w_last) begin
          q_col <= '0;
          q_row <= q_row + DIM_W'(1);
        end else begin
          q_col <= q_col + COL_W'(1);
        end
      end

      if (accept) begin
        s1_valid <= produce;
      end else if (s2_free) begin
        s1_valid <= 1'b0;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        gradient_valid <= s2_valid;
      end
    end
  end

  mgf_line_buffer u_line (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (line_wr),
    .rd_addr (col_next),
    .rd_data (taps)
  );

  mgf_window u_window (
    .clk      (clk),
    .shift_en (accept),
    .row0     (val),
    .taps     (taps),
    .win      (win)
  );

  mgf_reduce u_reduce (
    .clk        (clk),
    .adv        (adv),
    .win        (win),
    .sel        (sel),
    .meta1      (meta1),
    .gradient   (gradient),
    .frame_last (frame_last)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (s1_valid && s2_valid && gradient_valid))
    else $error("input stalled with a free pipeline stage");

  a_result_follows_lag: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid == $past(produce)))
    else $error("stage one valid does not match result condition");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= lag)
    else $error("fill count ran past the lag");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (fill == '0 && col == '0 && q_row == '0 && q_col == '0))
    else $error("counters not restarted after frame end");

endmodule

`default_nettype wire
